>>> rtl/ir_remote_frame_transmitter_macros.svh
// Assertion macros shared by the infrared remote frame transmitter.
`ifndef IR_REMOTE_FRAME_TRANSMITTER_MACROS_SVH
`define IR_REMOTE_FRAME_TRANSMITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRTX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("irtx check failed");

// The consequent must hold in the cycle after the antecedent.
`define IRTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("irtx check failed");

`endif

>>> rtl/irtx_pkg.sv
// Shared constants and types of the infrared remote frame transmitter.
`timescale 1ns / 1ps
package irtx_pkg;
	localparam int FRAME_BYTES = 6;
	localparam int DATA_W = 48;
	localparam int UNIT_W = 8;
	localparam logic [5:0] BITS_INIT = 6'(FRAME_BYTES * 8 - 1);
	localparam logic [UNIT_W-1:0] UNIT_RESET = 8'd16;
	localparam logic [4:0] SYNC_MARK_UNITS = 5'd8;
	localparam logic [4:0] SYNC_SPACE_UNITS = 5'd4;
	localparam logic [4:0] ONE_SPACE_UNITS = 5'd3;
	localparam logic [4:0] SHORT_UNITS = 5'd1;
	localparam logic [4:0] STOP_SPACE_UNITS = 5'd16;
	localparam logic REG_UNIT_PERIODS = 1'b0;
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic frame_done;
		logic accepted;
		logic busy_res;
		logic ir_mark;
	} res_t;
endpackage

>>> rtl/irtx_apb.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
module irtx_apb import irtx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [UNIT_W-1:0] unit_periods
);
	logic [UNIT_W-1:0] unit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_UNIT_PERIODS) begin
			unit_q <= pwdata[UNIT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_UNIT_PERIODS) ? {24'd0, unit_q} : 32'd0;
	assign unit_periods = unit_q;
endmodule

>>> rtl/irtx_seq.sv
// Frame sequencer: segment, unit and tick counters and the data shift register.
`timescale 1ns / 1ps
`include "ir_remote_frame_transmitter_macros.svh"
module irtx_seq import irtx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              cmd,
	input  logic [DATA_W-1:0] frame_data,
	input  logic [UNIT_W-1:0] unit_periods,
	output res_t              res
);
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_SYNC_MARK  = 3'd1,
		PH_SYNC_SPACE = 3'd2,
		PH_BIT_MARK   = 3'd3,
		PH_BIT_SPACE  = 3'd4,
		PH_STOP_MARK  = 3'd5,
		PH_STOP_SPACE = 3'd6
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [DATA_W-1:0] data_q, data_d;
	logic [5:0]        bits_q, bits_d;
	logic [4:0]        units_q, units_d;
	logic [UNIT_W-1:0] ticks_q, ticks_d;
	logic [UNIT_W-1:0] unit_len;
	logic              active;

	assign unit_len = (unit_periods == '0) ? UNIT_W'(1) : unit_periods;
	assign active = (phase_q != PH_IDLE);

	always_comb begin
		phase_d = phase_q;
		data_d = data_q;
		bits_d = bits_q;
		units_d = units_q;
		ticks_d = ticks_q;
		res = '0;
		if (cmd == CMD_START) begin
			res.busy_res = 1'b1;
			if (!active) begin
				res.accepted = 1'b1;
				data_d = frame_data;
				bits_d = BITS_INIT;
				phase_d = PH_SYNC_MARK;
				units_d = SYNC_MARK_UNITS;
				ticks_d = unit_len;
			end
		end else if (active) begin
			res.busy_res = 1'b1;
			res.ir_mark = (phase_q == PH_SYNC_MARK) || (phase_q == PH_BIT_MARK) ||
				(phase_q == PH_STOP_MARK);
			if (ticks_q > UNIT_W'(1)) begin
				ticks_d = ticks_q - UNIT_W'(1);
			end else if (units_q > 5'd1) begin
				units_d = units_q - 5'd1;
				ticks_d = unit_len;
			end else begin
				ticks_d = unit_len;
				case (phase_q)
					PH_SYNC_MARK: begin
						phase_d = PH_SYNC_SPACE;
						units_d = SYNC_SPACE_UNITS;
					end
					PH_SYNC_SPACE: begin
						phase_d = PH_BIT_MARK;
						units_d = SHORT_UNITS;
					end
					PH_BIT_MARK: begin
						phase_d = PH_BIT_SPACE;
						units_d = data_q[0] ? ONE_SPACE_UNITS : SHORT_UNITS;
					end
					PH_BIT_SPACE: begin
						data_d = {1'b0, data_q[DATA_W-1:1]};
						units_d = SHORT_UNITS;
						if (bits_q == '0) begin
							phase_d = PH_STOP_MARK;
						end else begin
							bits_d = bits_q - 6'd1;
							phase_d = PH_BIT_MARK;
						end
					end
					PH_STOP_MARK: begin
						phase_d = PH_STOP_SPACE;
						units_d = STOP_SPACE_UNITS;
					end
					default: begin
						phase_d = PH_IDLE;
						units_d = '0;
						ticks_d = '0;
						res.frame_done = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			data_q <= '0;
			bits_q <= '0;
			units_q <= '0;
			ticks_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			data_q <= data_d;
			bits_q <= bits_d;
			units_q <= units_d;
			ticks_q <= ticks_d;
		end
	end

	`IRTX_ASSERT_NEXT(a_start_loads, clk, arst_n, step && res.accepted, phase_q == PH_SYNC_MARK)
	`IRTX_ASSERT_SAME(a_done_in_stop, clk, arst_n, res.frame_done, phase_q == PH_STOP_SPACE)
	`IRTX_ASSERT_SAME(a_ticks_live, clk, arst_n, phase_q != PH_IDLE, ticks_q != '0 && units_q != '0)
	`IRTX_ASSERT_SAME(a_units_max, clk, arst_n, 1'b1, units_q <= STOP_SPACE_UNITS)
endmodule

>>> rtl/irtx_out.sv
// Result register that holds one word until the downstream side takes it.
`timescale 1ns / 1ps
module irtx_out import irtx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  res_t       res,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);
	logic valid_q;
	res_t res_q;

	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {5'd0, res_q.accepted, res_q.busy_res, res_q.ir_mark};
	assign m_tlast = res_q.frame_done;
endmodule

>>> rtl/ir_remote_frame_transmitter.sv
// Top level of the infrared remote frame transmitter.
`timescale 1ns / 1ps
// Each input word is either one carrier-period tick or a start command that loads a
// 48-bit frame; every word yields exactly one output word giving the mark/space
// envelope for that tick and the busy, accepted and frame-done flags. A start that
// arrives while a frame is running is refused. The block takes one word per clock
// cycle while the output side keeps up: the sequencer counters update in the accepting
// cycle and the result is loaded into the output register at the same clock edge; a
// new word is let in only while that register is empty or its word is being taken.
// The time unit is set by the unit_periods register at address 0 (0 acts as 1).
module ir_remote_frame_transmitter import irtx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // frame_data
	input  logic [0:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // ir_mark, busy_res, accepted, zero fill
	output logic        m_tlast,  // frame_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [UNIT_W-1:0] unit_periods;
	res_t              res;
	logic              step;

	assign step = s_tvalid && s_tready;

	irtx_apb u_apb (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.unit_periods(unit_periods)
	);

	irtx_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.cmd(s_tuser[0]),
		.frame_data(s_tdata),
		.unit_periods(unit_periods),
		.res(res)
	);

	irtx_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.res(res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);
endmodule

>>> verif/testbench.sv
// Self-checking testbench for the infrared remote frame transmitter.
`timescale 1ns / 1ps
module testbench;
	import irtx_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WORDS = 220;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SYNC_MARK, PH_SYNC_SPACE, PH_BIT_MARK,
		PH_BIT_SPACE, PH_STOP_MARK, PH_STOP_SPACE
	} tx_phase_t;

	typedef struct {
		logic        cmd;
		logic [47:0] frame;
	} tx_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // frame_data
	logic [0:0]  s_tuser = CMD_TICK;  // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // ir_mark, busy_res, accepted, zero fill
	logic        m_tlast;  // frame_done
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ir_remote_frame_transmitter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	tx_word_t  send_q[$];
	res_t      envelope_q[$];
	int        cycles = 0;
	int        errors = 0;
	int        results_seen = 0;
	int        words_sent = 0;
	int        frames_done = 0;
	int        starts_refused = 0;
	int        unit_settings = 0;
	bit        word_taken = 1'b0;

	// Expected transmitter state, kept in step with accepted words.
	logic [7:0]  unit_cfg = UNIT_RESET;
	tx_phase_t   phase_q = PH_IDLE;
	logic [47:0] shift_q = '0;
	logic [5:0]  bits_q = '0;
	logic [4:0]  units_q = '0;
	logic [7:0]  ticks_q = '0;

	function automatic logic [7:0] unit_len();
		return (unit_cfg == 8'd0) ? 8'd1 : unit_cfg;
	endfunction

	function automatic int frame_ticks(input logic [47:0] frame, input logic [7:0] unit);
		int units;
		units = SYNC_MARK_UNITS + SYNC_SPACE_UNITS + SHORT_UNITS + STOP_SPACE_UNITS;
		for (int i = 0; i < DATA_W; i++)
			units += frame[i] ? 4 : 2;
		return units * ((unit == 8'd0) ? 1 : unit);
	endfunction

	task automatic enter_segment(input tx_phase_t ph, input logic [4:0] units);
		phase_q = ph;
		units_q = units;
		ticks_q = unit_len();
	endtask

	task automatic envelope_step(input tx_word_t w, output res_t r);
		logic active;
		r = '0;
		active = phase_q inside {PH_SYNC_MARK, PH_SYNC_SPACE, PH_BIT_MARK,
			PH_BIT_SPACE, PH_STOP_MARK, PH_STOP_SPACE};
		if (w.cmd == CMD_START) begin
			if (!active) begin
				shift_q = w.frame;
				bits_q = BITS_INIT;
				enter_segment(PH_SYNC_MARK, SYNC_MARK_UNITS);
				r.accepted = 1'b1;
			end else begin
				starts_refused++;
			end
			r.busy_res = 1'b1;
			return;
		end
		if (!active) begin
			phase_q = PH_IDLE;
			return;
		end
		r.ir_mark = phase_q inside {PH_SYNC_MARK, PH_BIT_MARK, PH_STOP_MARK};
		r.busy_res = 1'b1;
		if (ticks_q > 8'd1) begin
			ticks_q--;
		end else if (units_q > 5'd1) begin
			units_q--;
			ticks_q = unit_len();
		end else begin
			case (phase_q)
				PH_SYNC_MARK: enter_segment(PH_SYNC_SPACE, SYNC_SPACE_UNITS);
				PH_SYNC_SPACE: enter_segment(PH_BIT_MARK, SHORT_UNITS);
				PH_BIT_MARK: begin
					enter_segment(PH_BIT_SPACE, shift_q[0] ? ONE_SPACE_UNITS : SHORT_UNITS);
				end
				PH_BIT_SPACE: begin
					shift_q = shift_q >> 1;
					if (bits_q == 6'd0) begin
						enter_segment(PH_STOP_MARK, SHORT_UNITS);
					end else begin
						bits_q--;
						enter_segment(PH_BIT_MARK, SHORT_UNITS);
					end
				end
				PH_STOP_MARK: enter_segment(PH_STOP_SPACE, STOP_SPACE_UNITS);
				default: begin
					phase_q = PH_IDLE;
					units_q = '0;
					ticks_q = '0;
					r.frame_done = 1'b1;
					frames_done++;
				end
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s is %0h, expected %0h", results_seen, what, got,
			want);
		errors++;
	endtask

	// Input side: predict on acceptance. Output side: compare against the oldest expectation.
	always @(posedge clk) begin
		res_t r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end else begin
			word_taken = s_tvalid && s_tready;
			if (word_taken) begin
				envelope_step(send_q[0], r);
				envelope_q.push_back(r);
				void'(send_q.pop_front());
				words_sent++;
			end
			if (m_tvalid && m_tready) begin
				if (envelope_q.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, 0);
				end else begin
					r = envelope_q.pop_front();
					if (m_tdata[0] !== r.ir_mark)
						report_mismatch("ir_mark", m_tdata[0], r.ir_mark);
					if (m_tdata[1] !== r.busy_res)
						report_mismatch("busy_res", m_tdata[1], r.busy_res);
					if (m_tdata[2] !== r.accepted)
						report_mismatch("accepted", m_tdata[2], r.accepted);
					if (m_tdata[7:3] !== 5'd0)
						report_mismatch("tdata fill", m_tdata[7:3], 0);
					if (m_tlast !== r.frame_done)
						report_mismatch("frame_done", m_tlast, r.frame_done);
				end
				results_seen++;
			end
		end
	end

	// Both sides idle about one cycle in ten, except in a recurring quiet window.
	always @(negedge clk) begin
		logic quiet;
		quiet = (cycles % 1000) >= 750;
		if (s_tvalid && !word_taken) begin
			s_tvalid <= 1'b1;
		end else if (send_q.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
			s_tvalid <= 1'b1;
			s_tuser <= send_q[0].cmd;
			s_tdata <= send_q[0].frame;
		end else begin
			s_tvalid <= 1'b0;
		end
		m_tready <= quiet || $urandom_range(99) >= 10;
	end

	function automatic logic [47:0] rand_word48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] rand_frame();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 48'h1 << $urandom_range(47);
			default: return rand_word48();
		endcase
	endfunction

	function automatic int queue_word(input logic cmd, input logic [47:0] frame);
		tx_word_t w;
		w.cmd = cmd;
		w.frame = frame;
		send_q.push_back(w);
		return 1;
	endfunction

	function automatic int queue_ticks(input int n);
		int k = 0;
		for (int i = 0; i < n; i++)
			k += queue_word(CMD_TICK, rand_word48());
		return k;
	endfunction

	// A start followed by enough ticks to finish, optionally cut short or with a stray start.
	function automatic int queue_frame(input logic [47:0] frame, input int extra, input bit cut);
		int n, k, stray;
		n = frame_ticks(frame, unit_cfg) + extra;
		if (cut)
			n = $urandom_range(1, (n > 200) ? 200 : n - 1);
		stray = ($urandom_range(9) == 0) ? $urandom_range(1, n) : -1;
		k = queue_word(CMD_START, frame);
		for (int i = 0; i < n; i++) begin
			if (i == stray)
				k += queue_word(CMD_START, rand_word48());
			k += queue_word(CMD_TICK, rand_word48());
		end
		return k;
	endfunction

	task automatic drain();
		while (send_q.size() != 0 || envelope_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_unit(input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_UNIT_PERIODS, 2'b00};
		pwdata <= {24'($urandom_range(0, 32'hFF_FFFF)), value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unit_cfg = value;
		unit_settings++;
	endtask

	initial begin
		int n;
		int random_words = 0;
		logic [47:0] lead_frame;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset unit length: an idle tick, then the first units of a frame.
		n = queue_ticks(1);
		lead_frame = rand_frame();
		n = queue_word(CMD_START, lead_frame);
		n = queue_ticks(20);
		drain();
		// Zero length mid-frame takes over at the next unit; the frame then runs out.
		write_unit(8'd0);
		n = queue_word(CMD_START, 48'h0);
		n = queue_ticks(frame_ticks(lead_frame, unit_cfg) + 12);
		n = queue_word(CMD_START, 48'hFFFF_FFFF_FFFF);
		n = queue_word(CMD_START, 48'h0);
		n = queue_ticks(frame_ticks(48'hFFFF_FFFF_FFFF, unit_cfg) + 1);
		drain();
		// The longest unit, left running into the random part.
		write_unit(8'd255);
		n = queue_frame(rand_frame(), 0, 1'b1);
		drain();

		while (random_words < RANDOM_WORDS) begin
			case ($urandom_range(9))
				6: write_unit(8'd2);
				7: write_unit(8'd3);
				8: write_unit(8'd0);
				9: write_unit(8'($urandom_range(4, 6)));
				default: write_unit(8'd1);
			endcase
			for (int s = $urandom_range(1, 2); s > 0; s--) begin
				if ($urandom_range(99) < 85) begin
					random_words += queue_frame(rand_frame(), $urandom_range(0, 4),
						unit_cfg > 8'd1 || $urandom_range(3) == 0);
				end else begin
					for (int i = $urandom_range(1, 6); i > 0; i--)
						random_words += queue_word($urandom_range(99) < 30 ? CMD_START : CMD_TICK,
							rand_word48());
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d words under %0d unit length settings, including 0, 1, 16 and 255.",
			words_sent, unit_settings + 1);
		$display("Saw %0d complete frames and %0d starts refused while busy.", frames_done,
			starts_refused);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
